// ----- sv/numlit_pkg.sv -----
// ----------------------------------------------------------------------------
// Numeric literal recognizer package
// Length limit, automaton state codes and character class helpers.
// ----------------------------------------------------------------------------
package numlit_pkg;

   localparam int unsigned MAX_MATCH_LEN = 4095;
   localparam int unsigned LEN_W         = $clog2(MAX_MATCH_LEN + 1);
   localparam int unsigned CHAR_W        = 16;
   localparam int unsigned OUT_LEN_W     = 12;
   localparam int unsigned STATE_W       = 4;

   typedef logic [CHAR_W-1:0]  char_type;
   typedef logic [LEN_W-1:0]   len_type;
   typedef logic [STATE_W-1:0] lex_state_type;

   localparam lex_state_type S_START    = 4'd0;
   localparam lex_state_type S_ZERO     = 4'd1;
   localparam lex_state_type S_BIN_PFX  = 4'd2;
   localparam lex_state_type S_BIN      = 4'd3;
   localparam lex_state_type S_OCT_PFX  = 4'd4;
   localparam lex_state_type S_OCT      = 4'd5;
   localparam lex_state_type S_HEX_PFX  = 4'd6;
   localparam lex_state_type S_HEX      = 4'd7;
   localparam lex_state_type S_INT      = 4'd8;
   localparam lex_state_type S_INT_DOT  = 4'd9;
   localparam lex_state_type S_LEAD_DOT = 4'd10;
   localparam lex_state_type S_FRAC     = 4'd11;
   localparam lex_state_type S_EXP      = 4'd12;
   localparam lex_state_type S_EXP_SIGN = 4'd13;
   localparam lex_state_type S_EXP_DIG  = 4'd14;

   localparam len_type LEN_MAX = LEN_W'(MAX_MATCH_LEN);

   // Folds ASCII upper case letters onto lower case; other codes pass.
   function automatic char_type lower_ascii(input char_type c);
      lower_ascii = (c >= char_type'("A") && c <= char_type'("Z")) ? c + char_type'(32) : c;
   endfunction

   function automatic logic is_dec(input char_type c);
      is_dec = (c >= char_type'("0")) && (c <= char_type'("9"));
   endfunction

   function automatic logic is_oct(input char_type c);
      is_oct = (c >= char_type'("0")) && (c <= char_type'("7"));
   endfunction

   function automatic logic is_bin(input char_type c);
      is_bin = (c == char_type'("0")) || (c == char_type'("1"));
   endfunction

   function automatic logic is_hex(input char_type c);
      char_type l;
      l = lower_ascii(c);
      is_hex = is_dec(c) || ((l >= char_type'("a")) && (l <= char_type'("f")));
   endfunction

endpackage

// ----- sv/numeric_literal_recognizer_top.sv -----
// ----------------------------------------------------------------------------
// Numeric literal recognizer
// Follows Python-style numeric literals one text character per transaction.
// ----------------------------------------------------------------------------
// The block takes one UTF-16 character per transaction and answers each with
// one result transaction: the length of the longest valid numeric prefix of
// the current attempt, a finished flag and a number flag. A character with
// req_tuser high starts a new attempt; one with req_tlast high is the last of
// the text and finishes the match. Once finished, further characters leave
// the result unchanged until the next attempt starts. The accepted literals
// are decimal integers, fractions, exponents, the 0b, 0o and 0x forms and a
// closing j or J, which ends the match at once. Lengths saturate at
// MAX_MATCH_LEN. Throughput is one character per cycle while results are
// taken: a character is registered at the input, goes through one automaton
// step and lands in the result register. The automaton step and the length
// counter update form the only feedback loop. While a result waits to be
// taken, the input still accepts one character into an empty input register;
// after that the input stalls until the result is taken.
// ----------------------------------------------------------------------------
module numeric_literal_recognizer_top (
   input  logic        clock,
   input  logic        reset,
   // Character channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] code_unit
   input  logic        req_tuser,   // [0] first_char
   input  logic        req_tlast,   // end_of_text
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [11:0] match_length, [15:12] zero
   output logic        rsp_tuser,   // [0] is_number
   output logic        rsp_tlast    // finished
);
   import numlit_pkg::*;

   // Input register stage.
   logic          in_valid_ff, in_valid_in;
   char_type      in_char_ff;
   logic          in_first_ff;
   logic          in_eot_ff;

   // Automaton state.
   lex_state_type state_ff, state_in;
   len_type       seen_ff, seen_in;
   len_type       best_ff, best_in;
   logic          done_ff, done_in;

   // Result register.
   logic                 out_valid_ff, out_valid_in;
   logic [OUT_LEN_W-1:0] out_len_ff;
   logic                 out_done_ff;
   logic                 out_num_ff;

   logic out_open;
   logic step;

   // The result register can take a new result when it is empty or being drained.
   assign out_open   = !out_valid_ff || rsp_tready;
   assign step       = in_valid_ff && out_open;
   assign req_tready = !in_valid_ff || out_open;

   assign in_valid_in  = (req_tvalid && req_tready) ? 1'b1 : (step ? 1'b0 : in_valid_ff);
   assign out_valid_in = step ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   // One automaton step for the character held in the input register.
   always_comb begin
      lex_state_type cur_state;
      len_type       cur_seen;
      len_type       cur_best;
      logic          cur_done;
      len_type       pos;
      char_type      c;
      char_type      l;
      logic          ok;
      logic          took_j;

      c = in_char_ff;
      l = lower_ascii(in_char_ff);

      // A new attempt starts from the reset state.
      cur_state = in_first_ff ? S_START : state_ff;
      cur_seen  = in_first_ff ? '0 : seen_ff;
      cur_best  = in_first_ff ? '0 : best_ff;
      cur_done  = in_first_ff ? 1'b0 : done_ff;

      pos    = (cur_seen == LEN_MAX) ? LEN_MAX : cur_seen + len_type'(1);
      ok     = 1'b0;
      took_j = 1'b0;

      state_in = cur_state;
      best_in  = cur_best;

      unique case (cur_state)
         S_START: begin
            if (c == char_type'("0")) begin
               state_in = S_ZERO; best_in = pos; ok = 1'b1;
            end else if (is_dec(c)) begin
               state_in = S_INT; best_in = pos; ok = 1'b1;
            end else if (c == char_type'(".")) begin
               state_in = S_LEAD_DOT; ok = 1'b1;
            end
         end
         S_ZERO: begin
            if (l == char_type'("b")) begin
               state_in = S_BIN_PFX; ok = 1'b1;
            end else if (l == char_type'("x")) begin
               state_in = S_HEX_PFX; ok = 1'b1;
            end else if (l == char_type'("o")) begin
               state_in = S_OCT_PFX; ok = 1'b1;
            end else if (is_dec(c)) begin
               state_in = S_INT; best_in = pos; ok = 1'b1;
            end else if (c == char_type'(".")) begin
               state_in = S_INT_DOT; best_in = pos; ok = 1'b1;
            end else if (l == char_type'("j")) begin
               best_in = pos; ok = 1'b1; took_j = 1'b1;
            end
         end
         S_BIN_PFX, S_BIN: begin
            if (is_bin(c)) begin
               state_in = S_BIN; best_in = pos; ok = 1'b1;
            end
         end
         S_OCT_PFX, S_OCT: begin
            if (is_oct(c)) begin
               state_in = S_OCT; best_in = pos; ok = 1'b1;
            end
         end
         S_HEX_PFX, S_HEX: begin
            if (is_hex(c)) begin
               state_in = S_HEX; best_in = pos; ok = 1'b1;
            end
         end
         S_INT: begin
            if (is_dec(c)) begin
               best_in = pos; ok = 1'b1;
            end else if (c == char_type'(".")) begin
               state_in = S_INT_DOT; best_in = pos; ok = 1'b1;
            end else if (l == char_type'("e")) begin
               state_in = S_EXP; ok = 1'b1;
            end else if (l == char_type'("j")) begin
               best_in = pos; ok = 1'b1; took_j = 1'b1;
            end
         end
         S_INT_DOT, S_FRAC: begin
            if (is_dec(c)) begin
               state_in = S_FRAC; best_in = pos; ok = 1'b1;
            end else if (l == char_type'("e")) begin
               state_in = S_EXP; ok = 1'b1;
            end else if (l == char_type'("j")) begin
               best_in = pos; ok = 1'b1; took_j = 1'b1;
            end
         end
         S_LEAD_DOT: begin
            if (is_dec(c)) begin
               state_in = S_FRAC; best_in = pos; ok = 1'b1;
            end
         end
         S_EXP: begin
            if (c == char_type'("+") || c == char_type'("-")) begin
               state_in = S_EXP_SIGN; ok = 1'b1;
            end else if (is_dec(c)) begin
               state_in = S_EXP_DIG; best_in = pos; ok = 1'b1;
            end
         end
         S_EXP_SIGN: begin
            if (is_dec(c)) begin
               state_in = S_EXP_DIG; best_in = pos; ok = 1'b1;
            end
         end
         S_EXP_DIG: begin
            if (is_dec(c)) begin
               best_in = pos; ok = 1'b1;
            end else if (l == char_type'("j")) begin
               best_in = pos; ok = 1'b1; took_j = 1'b1;
            end
         end
         default: begin
            ok = 1'b0;
         end
      endcase

      if (cur_done) begin
         // A finished match ignores further characters.
         state_in = cur_state;
         best_in  = cur_best;
         seen_in  = cur_seen;
         done_in  = 1'b1;
      end else begin
         seen_in = pos;
         done_in = !ok || took_j || in_eot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= S_START;
         seen_ff      <= '0;
         best_ff      <= '0;
         done_ff      <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (step) begin
            state_ff <= state_in;
            seen_ff  <= seen_in;
            best_ff  <= best_in;
            done_ff  <= done_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_char_ff  <= req_tdata;
         in_first_ff <= req_tuser;
         in_eot_ff   <= req_tlast;
      end
      if (step) begin
         out_len_ff  <= OUT_LEN_W'(best_in);
         out_done_ff <= done_in;
         out_num_ff  <= (OUT_LEN_W'(best_in) != '0);
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(16 - OUT_LEN_W){1'b0}}, out_len_ff};
   assign rsp_tlast  = out_done_ff;
   assign rsp_tuser  = out_num_ff;

endmodule

// ----- dv/numeric_literal_recognizer_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Numeric literal recognizer testbench
// Streams characters into the recognizer and checks every result transaction.
// ----------------------------------------------------------------------------
// A short table of probe characters opens the run. It covers the reset
// attempt, a non-ASCII character, a character ignored after finish, and the
// binary, octal, hex, fraction, exponent and j forms. Random attempts
// follow: mostly well-formed literals with random content, the rest noise and
// broken text. One attempt runs past the length limit. The run goes through
// four idling phases on the two channels, with one long hold-off on the
// result side. Each accepted character is fed to a local scanner, and its
// outcome is queued in order; every result transaction must match the
// oldest queued outcome field by field.
// ----------------------------------------------------------------------------
module numeric_literal_recognizer_top_tb;
   import numlit_pkg::*;

   // Result fields as the result channel carries them.
   typedef struct packed {
      logic [OUT_LEN_W-1:0] match_len;
      logic                 done;
      logic                 is_num;
   } lit_result_type;

   // One row of the probe table. Where typed is set, want is the outcome
   // that the row must produce; otherwise the scanner decides.
   typedef struct packed {
      char_type       code;
      logic           first;
      logic           eot;
      logic           typed;
      lit_result_type want;
   } probe_row_type;

   localparam lit_result_type NO_RESULT   = '0;
   localparam int             CYCLE_LIMIT = 1000000;

   localparam probe_row_type PROBE_ROWS [25] = '{
      // No start flag after reset: the first character still opens an attempt.
      '{char_type'("7"), 1'b0, 1'b0, 1'b1, '{12'd1, 1'b0, 1'b1}},
      // Top of the code range is not ASCII, so it ends the match at once.
      '{16'hFFFF,        1'b1, 1'b0, 1'b1, '{12'd0, 1'b1, 1'b0}},
      // Once finished, a character leaves the result as it was.
      '{16'h0000,        1'b0, 1'b0, 1'b1, '{12'd0, 1'b1, 1'b0}},
      // Binary, octal and hex forms, prefixes in both cases.
      '{char_type'("0"), 1'b1, 1'b0, 1'b0, NO_RESULT},
      '{char_type'("b"), 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{char_type'("1"), 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{char_type'("0"), 1'b1, 1'b0, 1'b0, NO_RESULT},
      '{char_type'("O"), 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{char_type'("7"), 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{char_type'("0"), 1'b1, 1'b0, 1'b0, NO_RESULT},
      '{char_type'("X"), 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{char_type'("f"), 1'b0, 1'b0, 1'b0, NO_RESULT},
      // Integer, dot, fraction, signed exponent and an upper case J suffix.
      '{char_type'("1"), 1'b1, 1'b0, 1'b0, NO_RESULT},
      '{char_type'("."), 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{char_type'("5"), 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{char_type'("e"), 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{char_type'("+"), 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{char_type'("3"), 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{char_type'("J"), 1'b0, 1'b0, 1'b0, NO_RESULT},
      // Leading dot, closed by the end of the text.
      '{char_type'("."), 1'b1, 1'b0, 1'b0, NO_RESULT},
      '{char_type'("9"), 1'b0, 1'b1, 1'b1, '{12'd2, 1'b1, 1'b1}},
      // A letter after exponent digits ends the match.
      '{char_type'("8"), 1'b1, 1'b0, 1'b0, NO_RESULT},
      '{char_type'("E"), 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{char_type'("1"), 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{char_type'("a"), 1'b0, 1'b0, 1'b0, NO_RESULT}
   };

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // [15:0] code_unit
   logic        req_tuser  = 1'b0; // [0] first_char
   logic        req_tlast  = 1'b0; // end_of_text
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // [11:0] match_length, [15:12] zero
   logic        rsp_tuser;         // [0] is_number
   logic        rsp_tlast;         // finished

   // Scanner state: our own copy of the automaton and its counters.
   lex_state_type lx_state = S_START;
   len_type       chars_taken = '0;
   len_type       longest = '0;
   logic          lit_done = 1'b0;

   lit_result_type awaited_matches [$];
   lit_result_type head_match;

   int          err_count = 0;
   int          cycle_count = 0;
   int          live_chars = 0;   // characters that the automaton actually took
   int          phase_goal;
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int          hold_request = 0;
   int          hold_left = 0;

   numeric_literal_recognizer_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Runs one character through the scanner and returns the result that the
   // block must give for it. Once the match is done, only a start flag
   // changes anything.
   function automatic lit_result_type scan_literal_char(input char_type cu, input logic first,
                                                        input logic eot);
      char_type       lc;
      logic           digit;
      logic           ok;
      logic           mark;
      logic           jclose;
      lex_state_type  nxt;
      int unsigned    pos;
      lit_result_type r;
      if (first) begin
         lx_state    = S_START;
         chars_taken = '0;
         longest     = '0;
         lit_done    = 1'b0;
      end
      if (!lit_done) begin
         pos = int'(chars_taken) + 1;
         if (pos > MAX_MATCH_LEN) begin
            pos = MAX_MATCH_LEN;
         end
         // Letters compare case-blind; anything above 'Z' passes unchanged.
         lc     = (cu >= "A" && cu <= "Z") ? cu + 16'd32 : cu;
         digit  = (cu >= "0" && cu <= "9");
         ok     = 1'b1;
         mark   = 1'b0;
         jclose = 1'b0;
         nxt    = lx_state;
         case (lx_state)
            S_START: begin
               if (cu == "0") begin
                  nxt = S_ZERO; mark = 1'b1;
               end else if (digit) begin
                  nxt = S_INT; mark = 1'b1;
               end else if (cu == ".") begin
                  nxt = S_LEAD_DOT;
               end else begin
                  ok = 1'b0;
               end
            end
            S_ZERO: begin
               if (lc == "b") nxt = S_BIN_PFX;
               else if (lc == "x") nxt = S_HEX_PFX;
               else if (lc == "o") nxt = S_OCT_PFX;
               else if (digit) begin
                  nxt = S_INT; mark = 1'b1;
               end else if (cu == ".") begin
                  nxt = S_INT_DOT; mark = 1'b1;
               end else if (lc == "j") begin
                  mark = 1'b1; jclose = 1'b1;
               end else begin
                  ok = 1'b0;
               end
            end
            S_BIN_PFX, S_BIN: begin
               if (cu == "0" || cu == "1") begin
                  nxt = S_BIN; mark = 1'b1;
               end else begin
                  ok = 1'b0;
               end
            end
            S_OCT_PFX, S_OCT: begin
               if (cu >= "0" && cu <= "7") begin
                  nxt = S_OCT; mark = 1'b1;
               end else begin
                  ok = 1'b0;
               end
            end
            S_HEX_PFX, S_HEX: begin
               if (digit || (lc >= "a" && lc <= "f")) begin
                  nxt = S_HEX; mark = 1'b1;
               end else begin
                  ok = 1'b0;
               end
            end
            S_INT: begin
               if (digit) mark = 1'b1;
               else if (cu == ".") begin
                  nxt = S_INT_DOT; mark = 1'b1;
               end else if (lc == "e") nxt = S_EXP;
               else if (lc == "j") begin
                  mark = 1'b1; jclose = 1'b1;
               end else begin
                  ok = 1'b0;
               end
            end
            S_INT_DOT, S_FRAC: begin
               if (digit) begin
                  nxt = S_FRAC; mark = 1'b1;
               end else if (lc == "e") nxt = S_EXP;
               else if (lc == "j") begin
                  mark = 1'b1; jclose = 1'b1;
               end else begin
                  ok = 1'b0;
               end
            end
            S_LEAD_DOT: begin
               if (digit) begin
                  nxt = S_FRAC; mark = 1'b1;
               end else begin
                  ok = 1'b0;
               end
            end
            S_EXP: begin
               if (cu == "+" || cu == "-") nxt = S_EXP_SIGN;
               else if (digit) begin
                  nxt = S_EXP_DIG; mark = 1'b1;
               end else begin
                  ok = 1'b0;
               end
            end
            S_EXP_SIGN: begin
               if (digit) begin
                  nxt = S_EXP_DIG; mark = 1'b1;
               end else begin
                  ok = 1'b0;
               end
            end
            S_EXP_DIG: begin
               if (digit) mark = 1'b1;
               else if (lc == "j") begin
                  mark = 1'b1; jclose = 1'b1;
               end else begin
                  ok = 1'b0;
               end
            end
            default: ok = 1'b0;
         endcase
         lx_state = nxt;
         if (mark) longest = len_type'(pos);
         chars_taken = len_type'(pos);
         if (!ok || jclose || eot) lit_done = 1'b1;
      end
      r.match_len = longest;
      r.done      = lit_done;
      r.is_num    = (longest != '0);
      return r;
   endfunction

   // Offers one character, idling first as the current phase asks, and waits
   // for the transaction. The outcome is queued once the character is taken.
   task automatic offer_char(input char_type cu, input logic first, input logic eot,
                             input logic typed, input lit_result_type typed_want);
      lit_result_type calc;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= cu;
      req_tuser  <= first;
      req_tlast  <= eot;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (first || !lit_done) live_chars++;
      calc = scan_literal_char(cu, first, eot);
      awaited_matches.push_back(typed ? typed_want : calc);
   endtask

   function automatic char_type any_digit(input int unsigned hi);
      return char_type'("0") + char_type'($urandom_range(0, hi));
   endfunction

   // Takes a lower case letter and returns it in either case.
   function automatic char_type either_case(input char_type c);
      return $urandom_range(0, 1) ? c - 16'd32 : c;
   endfunction

   // Builds one attempt: a literal of a random form with random content,
   // sometimes broken or replaced by noise, followed by whatever text comes
   // next, then sends it. Most attempts begin with the start flag; a few run
   // on from the previous one.
   task automatic send_random_attempt();
      char_type    text [$];
      int unsigned kind;
      int unsigned v;
      int unsigned stop_at;
      logic        lead_first;
      kind = $urandom_range(0, 8);
      case (kind)
         0: begin
            text.push_back(any_digit(9) | 16'h0001);
            repeat ($urandom_range(0, 5)) text.push_back(any_digit(9));
         end
         1: begin
            text.push_back("0");
            text.push_back(either_case("b"));
            repeat ($urandom_range(0, 6)) text.push_back(any_digit(1));
         end
         2: begin
            text.push_back("0");
            text.push_back(either_case("o"));
            repeat ($urandom_range(0, 6)) text.push_back(any_digit(7));
         end
         3: begin
            text.push_back("0");
            text.push_back(either_case("x"));
            repeat ($urandom_range(0, 6)) begin
               v = $urandom_range(0, 15);
               text.push_back(v < 10 ? any_digit(0) + char_type'(v)
                                     : either_case(char_type'("a") + char_type'(v - 10)));
            end
         end
         4: begin
            // With no integer digits this is the leading dot form.
            repeat ($urandom_range(0, 3)) text.push_back(any_digit(9));
            text.push_back(".");
            repeat ($urandom_range(0, 3)) text.push_back(any_digit(9));
         end
         5, 6: begin
            text.push_back(any_digit(9));
            if ($urandom_range(0, 1)) begin
               text.push_back(".");
               repeat ($urandom_range(0, 2)) text.push_back(any_digit(9));
            end
            text.push_back(either_case("e"));
            case ($urandom_range(0, 2))
               0: text.push_back("+");
               1: text.push_back("-");
               default: ;
            endcase
            repeat ($urandom_range(0, 3)) text.push_back(any_digit(9));
         end
         7: begin
            text.push_back("0");
            repeat ($urandom_range(0, 2)) text.push_back(any_digit(9));
         end
         default: begin
            repeat ($urandom_range(1, 4)) text.push_back(char_type'($urandom_range(0, 16'hFFFF)));
         end
      endcase
      if ($urandom_range(0, 2) == 0) text.push_back(either_case("j"));
      // Now and then one character is swapped for printable junk.
      if ($urandom_range(0, 9) == 0) begin
         text[$urandom_range(0, text.size() - 1)] = char_type'($urandom_range(16'h20, 16'h7E));
      end
      // Text that follows the literal; mostly printable, sometimes any code.
      repeat ($urandom_range(0, 3)) begin
         text.push_back(($urandom_range(0, 3) == 0) ? char_type'($urandom_range(0, 16'hFFFF))
                                                    : char_type'($urandom_range(16'h20, 16'h7E)));
      end
      stop_at    = ($urandom_range(0, 5) == 0) ? $urandom_range(0, text.size() - 1) : text.size();
      lead_first = ($urandom_range(0, 19) != 0);
      foreach (text[i]) begin
         offer_char(text[i], (i == 0) && lead_first, i == stop_at, 1'b0, NO_RESULT);
      end
   endtask

   // Result side: random stalls, or a counted hold-off when one is asked for.
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Every result transaction is matched against the oldest queued outcome.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_matches.size() == 0) begin
            err_count++;
            $display("%0t: result with none expected: tdata %h finished %b number %b",
                     $time, rsp_tdata, rsp_tlast, rsp_tuser);
         end else begin
            head_match = awaited_matches.pop_front();
            if (rsp_tdata != {4'b0, head_match.match_len}) begin
               err_count++;
               $display("%0t: match_length expected %0d got tdata %h",
                        $time, head_match.match_len, rsp_tdata);
            end
            if (rsp_tlast != head_match.done) begin
               err_count++;
               $display("%0t: finished expected %b got %b", $time, head_match.done, rsp_tlast);
            end
            if (rsp_tuser != head_match.is_num) begin
               err_count++;
               $display("%0t: is_number expected %b got %b",
                        $time, head_match.is_num, rsp_tuser);
            end
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("numeric_literal_recognizer_top verification failed");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < $size(PROBE_ROWS); i++) begin
         offer_char(PROBE_ROWS[i].code, PROBE_ROWS[i].first, PROBE_ROWS[i].eot,
                    PROBE_ROWS[i].typed, PROBE_ROWS[i].want);
      end

      // Four idling phases: none, sender idle, receiver stalling, both.
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
            default: begin send_idle_pct = 32; recv_stall_pct = 32; end
         endcase
         // In the first phase the result side holds off for a long stretch
         // while characters keep coming, so the block fills and stalls input.
         if (ph == 0) hold_request = 300;
         phase_goal = live_chars + 500;
         while (live_chars < phase_goal) send_random_attempt();
         if (ph == 0) begin
            // One integer longer than the length limit, closed by end of text.
            offer_char("1", 1'b1, 1'b0, 1'b0, NO_RESULT);
            repeat (4200) offer_char(any_digit(9), 1'b0, 1'b0, 1'b0, NO_RESULT);
            offer_char("5", 1'b0, 1'b1, 1'b0, NO_RESULT);
         end
      end

      req_tvalid <= 1'b0;
      recv_stall_pct = 0;
      while (awaited_matches.size() != 0) @(posedge clock);
      // Keep clocking so that a stray extra result would still show up.
      repeat (8) @(posedge clock);
      if (err_count == 0) begin
         $display("numeric_literal_recognizer_top verification clean");
      end else begin
         $display("numeric_literal_recognizer_top verification failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
sv/numlit_pkg.sv
sv/numeric_literal_recognizer_top.sv
dv/numeric_literal_recognizer_top_tb.sv
